// ===== sv/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// brs_pkg
// Shared constants and types of the brace record length scanner.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned MAXLEN_W = 16;
  localparam int unsigned LEN_W    = 17;
  localparam int unsigned TOTAL_W  = 25;
  localparam int unsigned COUNT_W  = 23;
  localparam int unsigned ADD_W    = LEN_W + 1;
  localparam int unsigned RESULT_W = TOTAL_W + COUNT_W;

  localparam logic [BYTE_W-1:0]   OPEN_BRACE    = 8'h7B;
  localparam logic [BYTE_W-1:0]   CLOSE_BRACE   = 8'h7D;
  localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET = 16'd512;
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX     = {TOTAL_W{1'b1}};
  localparam logic [COUNT_W-1:0]  COUNT_MAX     = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [COUNT_W-1:0] record_count;
    logic [TOTAL_W-1:0] joined_length;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } result_push_t;

endpackage

// ===== sv/brace_record_length_scanner_top.sv =====
// ----------------------------------------------------------------------------
// brace_record_length_scanner_top
// Finds brace-framed records in a byte stream and reports their joined
// length and count at the end of each range.
// ----------------------------------------------------------------------------
// One byte is taken in every cycle while s_tready is high; the framing state,
// record length, total and count are updated in the same cycle by a compare
// and short adds. The result of a byte marked last appears on the master side
// in the cycle after its transfer when the result register is free, otherwise
// once the result ahead of it has been taken. Results wait in a two-entry buffer
// (result register and skid entry); s_tready drops only while both entries are full.
module brace_record_length_scanner_top
  import brs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [MAXLEN_W-1:0] cfg_wr_data,   // max_record_len
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [BYTE_W-1:0]   s_tdata,       // [7:0] data_byte
  input  logic                s_tlast,       // last_byte
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [RESULT_W-1:0] m_tdata        // [24:0] joined_length, [47:25] record_count
);

  result_push_t push;
  result_t      out_data;
  logic         in_fire;

  assign in_fire = s_tvalid && s_tready;
  assign m_tdata = out_data;

  brs_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_fire     (in_fire),
    .in_byte     (s_tdata),
    .in_last     (s_tlast),
    .push        (push)
  );

  brs_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_data)
  );

endmodule

// ===== sv/brs_scan.sv =====
// ----------------------------------------------------------------------------
// brs_scan
// Record framing state and per-byte update of length, total and count.
// ----------------------------------------------------------------------------
module brs_scan
  import brs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [MAXLEN_W-1:0] cfg_wr_data,
  input  logic                in_fire,
  input  logic [BYTE_W-1:0]   in_byte,
  input  logic                in_last,
  output result_push_t        push
);

  logic [MAXLEN_W-1:0] max_record_len;
  logic                in_record;
  logic [LEN_W-1:0]    current_length;
  logic [TOTAL_W-1:0]  running_total;
  logic [COUNT_W-1:0]  records_seen;

  logic                in_record_next;
  logic [LEN_W-1:0]    current_length_next;
  logic [TOTAL_W-1:0]  running_total_next;
  logic [COUNT_W-1:0]  records_seen_next;

  logic [LEN_W-1:0]    len_inc;
  logic [ADD_W-1:0]    add;
  logic [TOTAL_W:0]    sum;
  logic [TOTAL_W-1:0]  joined;

  always_comb begin
    len_inc             = current_length + LEN_W'(1);
    add                 = {1'b0, len_inc} + ADD_W'(1);
    sum                 = {1'b0, running_total} + (TOTAL_W+1)'(add);
    in_record_next      = in_record;
    current_length_next = current_length;
    running_total_next  = running_total;
    records_seen_next   = records_seen;
    if (!in_record) begin
      if (in_byte == OPEN_BRACE) begin
        in_record_next      = 1'b1;
        current_length_next = LEN_W'(1);
      end
    end else if (in_byte == CLOSE_BRACE) begin
      running_total_next  = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
      records_seen_next   = (records_seen == COUNT_MAX) ? COUNT_MAX
                                                        : records_seen + COUNT_W'(1);
      in_record_next      = 1'b0;
      current_length_next = '0;
    end else if (in_byte == OPEN_BRACE) begin
      in_record_next      = 1'b0;
      current_length_next = '0;
    end else begin
      current_length_next = len_inc;
      if (len_inc > {1'b0, max_record_len}) begin
        in_record_next      = 1'b0;
        current_length_next = '0;
      end
    end
  end

  always_comb begin
    if (running_total_next == '0) begin
      joined = '0;
    end else if (running_total_next == TOTAL_MAX) begin
      joined = TOTAL_MAX;
    end else begin
      joined = running_total_next - TOTAL_W'(1);
    end
    push.valid              = in_fire && in_last;
    push.data.joined_length = joined;
    push.data.record_count  = records_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_record_len <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_record_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_record      <= 1'b0;
      current_length <= '0;
      running_total  <= '0;
      records_seen   <= '0;
    end else if (in_fire) begin
      if (in_last) begin
        in_record      <= 1'b0;
        current_length <= '0;
        running_total  <= '0;
        records_seen   <= '0;
      end else begin
        in_record      <= in_record_next;
        current_length <= current_length_next;
        running_total  <= running_total_next;
        records_seen   <= records_seen_next;
      end
    end
  end

endmodule

// ===== sv/brs_out_buf.sv =====
// ----------------------------------------------------------------------------
// brs_out_buf
// Result register with a skid entry behind it, so that the scanner keeps
// taking bytes while a result waits for the downstream side.
// ----------------------------------------------------------------------------
module brs_out_buf
  import brs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  result_push_t push,
  output logic         push_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output result_t      out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign push_ready = !skid_valid;
  assign pop        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else if (push.valid) begin
          out_data <= push.data;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (push.valid) begin
        if (!out_valid) begin
          out_valid <= 1'b1;
          out_data  <= push.data;
        end else begin
          skid_valid <= 1'b1;
          skid_data  <= push.data;
        end
      end
    end
  end

endmodule

// ===== tb/sv/brs_scan_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_scan_checker
// Watches the byte and result channels of the brace record length scanner,
// predicts every range summary from the accepted bytes and the written
// limit, and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module brs_scan_checker
  import brs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [MAXLEN_W-1:0] cfg_wr_data,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [BYTE_W-1:0]   s_tdata,
  input  logic                s_tlast,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [RESULT_W-1:0] m_tdata,
  output int                  outstanding,
  output int                  fail_count
);

  logic [MAXLEN_W-1:0] limit_q = MAX_LEN_RESET;
  logic                in_rec = 1'b0;
  logic [LEN_W-1:0]    rec_len = '0;
  logic [TOTAL_W-1:0]  total = '0;
  logic [COUNT_W-1:0]  count = '0;
  result_t             summary_q[$];
  int                  errors = 0;

  function automatic void clear_range();
    in_rec  = 1'b0;
    rec_len = '0;
    total   = '0;
    count   = '0;
  endfunction

  function automatic void scan_byte(input logic [BYTE_W-1:0] b, input logic last);
    logic [LEN_W-1:0]   len_inc;
    logic [ADD_W-1:0]   add;
    logic [TOTAL_W:0]   sum;
    result_t            res;
    if (!in_rec) begin
      if (b == OPEN_BRACE) begin
        in_rec  = 1'b1;
        rec_len = LEN_W'(1);
      end
    end else if (b == CLOSE_BRACE) begin
      len_inc = rec_len + 1'b1;
      add     = {1'b0, len_inc} + 1'b1;
      sum     = total + add;
      if (sum > TOTAL_MAX) begin
        total = TOTAL_MAX;
      end else begin
        total = sum[TOTAL_W-1:0];
      end
      if (count != COUNT_MAX) begin
        count = count + 1'b1;
      end
      in_rec  = 1'b0;
      rec_len = '0;
    end else if (b == OPEN_BRACE) begin
      in_rec  = 1'b0;
      rec_len = '0;
    end else begin
      rec_len = rec_len + 1'b1;
      if (rec_len > limit_q) begin
        in_rec  = 1'b0;
        rec_len = '0;
      end
    end
    if (last) begin
      // The final separator is not part of the joined length, except once
      // the total has saturated.
      if (total == '0) begin
        res.joined_length = '0;
      end else if (total == TOTAL_MAX) begin
        res.joined_length = TOTAL_MAX;
      end else begin
        res.joined_length = total - 1'b1;
      end
      res.record_count = count;
      summary_q.push_back(res);
      clear_range();
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      limit_q = MAX_LEN_RESET;
      clear_range();
      summary_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (summary_q.size() == 0) begin
          $error("unexpected result transfer: joined_length %0d, record_count %0d",
                 got.joined_length, got.record_count);
          errors++;
        end else begin
          want = summary_q.pop_front();
          if (got.joined_length !== want.joined_length) begin
            $error("joined_length mismatch: expected %0d, actual %0d",
                   want.joined_length, got.joined_length);
            errors++;
          end
          if (got.record_count !== want.record_count) begin
            $error("record_count mismatch: expected %0d, actual %0d",
                   want.record_count, got.record_count);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        scan_byte(s_tdata, s_tlast);
      end
      if (cfg_wr_en) begin
        limit_q = cfg_wr_data;
      end
    end
    outstanding <= summary_q.size();
    fail_count  <= errors;
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the brace record length scanner.
// Drives directed ranges and then random ranges of well-formed, broken and
// overlong records under several record length limits and flow-control mixes,
// while a checker predicts and compares every range summary.
// ----------------------------------------------------------------------------
module testbench;
  import brs_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [MAXLEN_W-1:0] cfg_wr_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [BYTE_W-1:0]   s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [RESULT_W-1:0] m_tdata;

  logic                stall_req = 1'b0;
  int                  stall_left = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  outstanding;
  int                  fail_count;
  int                  bytes_sent = 0;
  logic [MAXLEN_W-1:0] cur_limit = MAX_LEN_RESET;

  always #1 clk = ~clk;

  brace_record_length_scanner_top uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  brs_scan_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  // A stall request holds the result side off for a long stretch.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (stall_req) begin
        stall_left <= 400;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end
      m_tready <= !stall_req && stall_left <= 1 &&
                  ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic logic [BYTE_W-1:0] noise_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (b == OPEN_BRACE);
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] filler_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (b == OPEN_BRACE || b == CLOSE_BRACE);
    return b;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
  endtask

  // Waits until every predicted summary has been received and the block has
  // had time to finish any byte that produced no result.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(input logic [MAXLEN_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    cur_limit   = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_range();
    logic [BYTE_W-1:0] seq[$];
    int n_rec;
    int body;
    int kind;
    n_rec = $urandom_range(0, 5);
    repeat (n_rec) begin
      repeat ($urandom_range(0, 2)) seq.push_back(noise_byte());
      kind = $urandom_range(0, 99);
      if (cur_limit <= 64 && $urandom_range(0, 3) == 0) begin
        body = int'(cur_limit) - 2 + int'($urandom_range(0, 2));
      end else begin
        body = $urandom_range(0, 12);
      end
      if (body < 0) begin
        body = 0;
      end
      seq.push_back(OPEN_BRACE);
      repeat (body) seq.push_back(filler_byte());
      // Most records close; some are cut by a nested open brace or left open.
      if (kind < 80) begin
        seq.push_back(CLOSE_BRACE);
      end else if (kind < 90) begin
        seq.push_back(OPEN_BRACE);
      end
    end
    if (seq.size() == 0 || $urandom_range(0, 2) == 0) begin
      seq.push_back(noise_byte());
    end
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
  endtask

  initial begin
    int target;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 27;
    recv_idle_pct <= 65;
    @(posedge clk);

    // Lone byte, stray close brace, nested open brace and open record at
    // range end under the reset limit.
    send_byte(8'h00, 1'b1);
    send_byte(CLOSE_BRACE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(OPEN_BRACE, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(CLOSE_BRACE, 1'b0);
    send_byte(OPEN_BRACE, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(OPEN_BRACE, 1'b0);
    send_byte(OPEN_BRACE, 1'b0);
    send_byte(CLOSE_BRACE, 1'b1);
    send_byte(OPEN_BRACE, 1'b0);
    send_byte(8'h01, 1'b1);

    // A zero limit still lets an empty record complete.
    drain();
    write_limit('0);
    send_byte(OPEN_BRACE, 1'b0);
    send_byte(CLOSE_BRACE, 1'b0);
    send_byte(OPEN_BRACE, 1'b0);
    send_byte(8'h7C, 1'b0);
    send_byte(CLOSE_BRACE, 1'b0);
    send_byte(OPEN_BRACE, 1'b0);
    send_byte(CLOSE_BRACE, 1'b1);

    drain();
    write_limit(16'd1);
    send_byte(OPEN_BRACE, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(CLOSE_BRACE, 1'b0);
    send_byte(OPEN_BRACE, 1'b0);
    send_byte(CLOSE_BRACE, 1'b1);

    for (int regime = 0; regime < 3; regime++) begin
      for (int sub = 0; sub < 3; sub++) begin
        drain();
        send_idle_pct = (regime == 0) ? 27 : (regime == 1) ? 65 : 0;
        recv_idle_pct <= (regime == 0) ? 65 : (regime == 1) ? 27 : 0;
        case (regime * 3 + sub)
          0:       write_limit(MAX_LEN_RESET);
          1:       write_limit(MAXLEN_W'($urandom_range(2, 24)));
          2:       write_limit('0);
          3:       write_limit(16'd1);
          4:       write_limit(MAXLEN_W'($urandom_range(25, 70)));
          6:       write_limit(MAXLEN_W'($urandom_range(2, 16)));
          7:       write_limit(MAXLEN_W'($urandom_range(100, 600)));
          default: write_limit(16'hFFFF);
        endcase
        if (regime == 0 && sub == 0) begin
          // Results pile up behind a stalled receiver until the input stalls.
          stall_req <= 1'b1;
          @(posedge clk);
          stall_req <= 1'b0;
          repeat (12) begin
            send_byte(OPEN_BRACE, 1'b0);
            send_byte(CLOSE_BRACE, 1'b1);
          end
          drain();
        end
        target = bytes_sent + 150;
        while (bytes_sent < target) send_range();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("brace_record_length_scanner_top verification clean");
    end else begin
      $display("brace_record_length_scanner_top verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("brace_record_length_scanner_top verification failed");
    $finish;
  end

endmodule
